### design/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// Touch button press classifier package
// Shared types and constants for the classifier and its divider.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEB,
        ST_CMP,
        ST_SEL,
        ST_DIV,
        ST_FIN
    } t_state;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SHORT = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_BOOT  = 2'd3;

    localparam logic [2:0] REG_RESET_HOLD  = 3'd0;
    localparam logic [2:0] REG_BOOT_HOLD   = 3'd1;
    localparam logic [2:0] REG_RESET_BLINK = 3'd2;
    localparam logic [2:0] REG_BOOT_BLINK  = 3'd3;
    localparam logic [2:0] REG_PRESS_CNT   = 3'd4;
    localparam logic [2:0] REG_RELEASE_CNT = 3'd5;
    localparam logic [2:0] REG_LED_LOW     = 3'd6;

    localparam logic [31:0] MS_DIVISOR = 32'd1000;
    localparam logic [7:0]  RUN_MAX    = 8'hff;

    // A 32-bit value divided by 1000 is its product with this reciprocal,
    // shifted right by MS_SHIFT.
    localparam logic [28:0] MS_RECIP = 29'd274877907;
    localparam int          MS_SHIFT = 38;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        quot_lsb;
    } t_div_rsp;

endpackage

### design/touch_button_press_classifier.sv
// ----------------------------------------------------------------------------
// Touch button press classifier
// Debounces touch samples, tracks the button and classifies each release.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one poll: a microsecond time and a
// touch sample. Every poll gives exactly one result on the master stream
// with the LED drive, the release action, the short press length in ms and
// the qualified touch level. Registers are written through the cfg channel,
// which is always ready and must only be used while the block is idle.
// A poll passes through the debounce, compare and select states to the
// output register, and also through the divider state when a blink phase
// is needed; the shared divider retires one quotient bit per cycle over 64
// dividend bits. The block takes one poll at a time and is not ready while
// it works on one. A finished result waits in the output register, so the
// next poll may be accepted while the receiver stalls; the block then holds
// its next result until the register is free. Reset clears the debounce and
// button state, empties the output register and loads the register
// defaults.
// ----------------------------------------------------------------------------
module touch_button_press_classifier
    import tbpc_pkg::*;
#(
    parameter int TOUCH_READS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_us [63:0], reads_until_high [68:64], zero fill above.
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // led_update [0], led_pin [1], action [3:2], press_ms [19:4],
    // touch_level [20], zero fill above.
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [7:0] READS_MAX = 8'(TOUCH_READS);

    t_state r_state;
    t_state n_state;

    logic [31:0] r_reset_hold;
    logic [31:0] r_boot_hold;
    logic [31:0] r_reset_blink;
    logic [31:0] r_boot_blink;
    logic [7:0]  r_press_cnt;
    logic [7:0]  r_release_cnt;
    logic        r_led_low;

    logic        r_touch_q;
    logic        r_seen;
    logic [63:0] r_press_start;
    logic [7:0]  r_nc_run;
    logic [7:0]  r_fc_run;

    logic [63:0] r_now;
    logic [4:0]  r_reads;
    logic [63:0] r_d;
    logic        r_ge_boot;
    logic        r_ge_reset;
    logic        r_gt_boot;
    logic        r_gt_reset;

    logic        r_led_update;
    logic        r_led_pin;
    logic [1:0]  r_action;
    logic [15:0] r_press_ms;

    logic        r_m_tvalid;
    logic [23:0] r_m_tdata;

    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_load_out;
    logic        w_edge;
    logic        w_release;
    logic        w_held;
    logic        w_div_go;
    logic [7:0]  w_nc_inc;
    logic [7:0]  w_fc_inc;
    logic        w_max_sample;
    logic [31:0] w_blink;
    logic [60:0] w_ms_prod;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    assign w_nc_inc     = (r_nc_run == RUN_MAX) ? RUN_MAX : r_nc_run + 8'd1;
    assign w_fc_inc     = (r_fc_run == RUN_MAX) ? RUN_MAX : r_fc_run + 8'd1;
    assign w_max_sample = ({3'b000, r_reads} >= READS_MAX);

    // A short press never lasts past a 32-bit hold threshold.
    assign w_ms_prod = {29'd0, r_d[31:0]} * {32'd0, MS_RECIP};

    assign w_edge    = (r_touch_q != r_seen);
    assign w_release = w_edge && !r_touch_q;
    assign w_held    = !w_edge && r_seen;
    assign w_div_go  = w_held && (r_ge_boot || r_ge_reset);

    always_comb begin
        w_blink = r_ge_boot ? r_boot_blink : r_reset_blink;
        if (w_blink == 32'd0) begin
            w_blink = 32'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DEB;
                end
            end
            ST_DEB: n_state = ST_CMP;
            ST_CMP: n_state = ST_SEL;
            ST_SEL: n_state = w_div_go ? ST_DIV : ST_FIN;
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready      = (r_state == ST_IDLE);
        w_load_out         = (r_state == ST_FIN) && (!r_m_tvalid || m_axis_tready);
        w_div_req.start    = (r_state == ST_SEL) && w_div_go;
        w_div_req.dividend = r_d - {32'd0, r_ge_boot ? r_boot_hold : r_reset_hold};
        w_div_req.divisor  = w_blink;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_hold  <= 32'd3000000;
            r_boot_hold   <= 32'd8000000;
            r_reset_blink <= 32'd250000;
            r_boot_blink  <= 32'd100000;
            r_press_cnt   <= 8'd60;
            r_release_cnt <= 8'd90;
            r_led_low     <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                REG_RESET_HOLD:  r_reset_hold  <= i_cfg_data;
                REG_BOOT_HOLD:   r_boot_hold   <= i_cfg_data;
                REG_RESET_BLINK: r_reset_blink <= i_cfg_data;
                REG_BOOT_BLINK:  r_boot_blink  <= i_cfg_data;
                REG_PRESS_CNT:   r_press_cnt   <= i_cfg_data[7:0];
                REG_RELEASE_CNT: r_release_cnt <= i_cfg_data[7:0];
                REG_LED_LOW:     r_led_low     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_q     <= 1'b0;
            r_seen        <= 1'b0;
            r_press_start <= '0;
            r_nc_run      <= '0;
            r_fc_run      <= '0;
        end else begin
            if (r_state == ST_DEB) begin
                if (w_max_sample) begin
                    r_nc_run <= w_nc_inc;
                    r_fc_run <= '0;
                    if (w_nc_inc > r_press_cnt) begin
                        r_touch_q <= 1'b1;
                    end
                end else begin
                    r_nc_run <= '0;
                    if (r_reads == 5'd0) begin
                        r_fc_run <= w_fc_inc;
                        if (w_fc_inc > r_release_cnt) begin
                            r_touch_q <= 1'b0;
                        end
                    end else if (r_fc_run > r_release_cnt) begin
                        r_touch_q <= 1'b0;
                    end
                end
            end
            if (r_state == ST_SEL && w_edge) begin
                r_seen <= r_touch_q;
                if (r_touch_q) begin
                    r_press_start <= r_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now   <= s_axis_tdata[63:0];
            r_reads <= s_axis_tdata[68:64];
        end
        if (r_state == ST_DEB) begin
            r_d <= r_now - r_press_start;
        end
        if (r_state == ST_CMP) begin
            r_ge_boot  <= (r_d[63:32] != 32'd0) || (r_d[31:0] >= r_boot_hold);
            r_ge_reset <= (r_d[63:32] != 32'd0) || (r_d[31:0] >= r_reset_hold);
            r_gt_boot  <= (r_d[63:32] != 32'd0) || (r_d[31:0] > r_boot_hold);
            r_gt_reset <= (r_d[63:32] != 32'd0) || (r_d[31:0] > r_reset_hold);
        end
        if (r_state == ST_SEL) begin
            r_led_update <= w_release || w_held;
            r_led_pin    <= 1'b0;
            r_action     <= ACT_NONE;
            r_press_ms   <= '0;
            if (w_release) begin
                r_led_pin <= r_led_low;
                if (r_gt_boot) begin
                    r_action <= ACT_BOOT;
                end else if (r_gt_reset) begin
                    r_action <= ACT_RESET;
                end else begin
                    r_action   <= ACT_SHORT;
                    r_press_ms <= w_ms_prod[MS_SHIFT +: 16];
                end
            end else if (w_held) begin
                r_led_pin <= ~r_led_low;
            end
        end
        if (r_state == ST_DIV && w_div_rsp.done) begin
            r_led_pin <= ~w_div_rsp.quot_lsb ^ r_led_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_tdata <= {3'b000, r_touch_q, r_press_ms, r_action, r_led_pin, r_led_update};
        end
    end

    tbpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign o_cfg_ready   = 1'b1;

endmodule

### design/tbpc_div.sv
// ----------------------------------------------------------------------------
// Touch button press classifier divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle. Returns the lowest quotient bit with a done pulse.
// ----------------------------------------------------------------------------
module tbpc_div
    import tbpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_work;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_shift = {r_rem, r_work[63]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[31:0] : w_shift[31:0];
            r_work <= {r_work[62:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quot_lsb = r_work[0];

endmodule
